[rtl/rvs_pkg.sv]
// Shared types, constants and helpers for the radial vignette shading unit.
`timescale 1ns / 1ps
package rvs_pkg;

  localparam int DIM_MAX   = 4096;
  localparam int POS_W     = $clog2(DIM_MAX);
  localparam int DIM_W     = POS_W + 1;
  localparam int CH_W      = 8;
  localparam int FAC_W     = 17;
  localparam int MASK_W    = 2 * FAC_W;
  localparam int STR_W     = 17;
  localparam int RCP_W     = 32;
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 2;

  localparam logic [FAC_W-1:0] ONE_Q16 = FAC_W'(65536);

  localparam logic [DIM_W-1:0] WIDTH_RST    = DIM_W'(640);
  localparam logic [DIM_W-1:0] HEIGHT_RST   = DIM_W'(480);
  localparam logic [STR_W-1:0] STRENGTH_RST = STR_W'(32768);
  localparam logic [RCP_W-1:0] RECIP_RST    = RCP_W'(7158);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WIDTH,
    CFG_HEIGHT,
    CFG_STRENGTH,
    CFG_RECIP
  } cfg_idx_t;

  typedef struct packed {
    logic             start;
    logic [POS_W-1:0] pos;
    logic [DIM_W-1:0] dim;
  } axis_req_t;

  typedef struct packed {
    logic [POS_W-1:0] col;
    logic [POS_W-1:0] row;
    logic [FAC_W-1:0] row_factor;
  } pos_state_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] d);
    logic [DIM_W-1:0] r;
    r = d;
    if (d == '0) r = DIM_W'(1);
    else if (d > DIM_W'(DIM_MAX)) r = DIM_W'(DIM_MAX);
    return r;
  endfunction

endpackage

[rtl/rvs_ifs.sv]
// Stream interfaces for pixels in and shaded pixels out.
`timescale 1ns / 1ps
interface rvs_in_if;
  import rvs_pkg::*;
  logic            valid;
  logic            ready;
  logic            frame_start;
  logic [CH_W-1:0] pixel_b;
  logic [CH_W-1:0] pixel_g;
  logic [CH_W-1:0] pixel_r;
  modport source(output valid, frame_start, pixel_b, pixel_g, pixel_r, input ready);
  modport sink(input valid, frame_start, pixel_b, pixel_g, pixel_r, output ready);
endinterface

interface rvs_out_if;
  import rvs_pkg::*;
  logic            valid;
  logic            ready;
  logic [CH_W-1:0] shaded_b;
  logic [CH_W-1:0] shaded_g;
  logic [CH_W-1:0] shaded_r;
  logic            frame_last;
  modport source(output valid, shaded_b, shaded_g, shaded_r, frame_last, input ready);
  modport sink(input valid, shaded_b, shaded_g, shaded_r, frame_last, output ready);
endinterface

[rtl/rvs_state_mem.sv]
// Position and row factor store with registered read.
`timescale 1ns / 1ps
module rvs_state_mem (
  input  logic                clk,
  input  logic                rst,
  input  logic                we,
  input  rvs_pkg::pos_state_t wdata,
  input  logic                re,
  output rvs_pkg::pos_state_t rdata
);
  import rvs_pkg::*;

  pos_state_t mem [0:0];
  logic       written;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[0] <= wdata;
    end
    if (re) begin
      rdata <= written ? mem[0] : '{col: '0, row: '0, row_factor: ONE_Q16};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written <= 1'b0;
    end else if (we) begin
      written <= 1'b1;
    end
  end

endmodule

[rtl/rvs_axis.sv]
// Multi-cycle axis factor unit: 1 - s*(2p-d)^2/N in Q16.
`timescale 1ns / 1ps
module rvs_axis (
  input  logic                      clk,
  input  logic                      rst,
  input  rvs_pkg::axis_req_t        req,
  input  logic [rvs_pkg::STR_W-1:0] strength,
  input  logic [rvs_pkg::RCP_W-1:0] recip,
  output logic                      done,
  output logic [rvs_pkg::FAC_W-1:0] f
);
  import rvs_pkg::*;

  localparam int A2_W = 2 * DIM_W;
  localparam int T_W  = A2_W + RCP_W;
  localparam int Q_W  = 18;
  localparam int SP_W = STR_W + Q_W;

  logic [DIM_W-1:0] twice;
  logic [DIM_W-1:0] a;
  logic [A2_W-1:0]  a2;
  logic [T_W-1:0]   t;
  logic [T_W:0]     t_rnd;
  logic [Q_W-1:0]   q_sat;
  logic [SP_W-1:0]  sqp;
  logic [SP_W:0]    sq_rnd;
  logic [SP_W-16:0] sq;
  logic [1:0]       step;
  logic             busy;

  assign twice  = {req.pos, 1'b0};
  assign a      = (twice >= req.dim) ? (twice - req.dim) : (req.dim - twice);
  assign t_rnd  = {1'b0, t} + (T_W+1)'(32768);
  assign q_sat  = (t_rnd[T_W:16] > (T_W-15)'(131072)) ? Q_W'(131072) : t_rnd[16+Q_W-1:16];
  assign sq_rnd = {1'b0, sqp} + (SP_W+1)'(32768);
  assign sq     = sq_rnd[SP_W:16];

  always_ff @(posedge clk) begin
    if (req.start) begin
      a2 <= {{DIM_W{1'b0}}, a} * {{DIM_W{1'b0}}, a};
    end
    t   <= {{RCP_W{1'b0}}, a2} * {{A2_W{1'b0}}, recip};
    sqp <= {{Q_W{1'b0}}, strength} * {{STR_W{1'b0}}, q_sat};
    f   <= (sq >= (SP_W-15)'(65536)) ? '0 : FAC_W'((SP_W-15)'(65536) - sq);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 2'd1;
        if (step == 2'd2) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

[rtl/rvs_shade.sv]
// One channel times the Q32 mask, rounded and clamped to the channel range.
`timescale 1ns / 1ps
module rvs_shade (
  input  logic [rvs_pkg::MASK_W-1:0] mask,
  input  logic [rvs_pkg::CH_W-1:0]   pixel,
  output logic [rvs_pkg::CH_W-1:0]   shaded
);
  import rvs_pkg::*;

  localparam int P_W = MASK_W + CH_W;

  logic [P_W-1:0]   prod;
  logic [P_W:0]     rnd;
  logic [P_W-32:0]  v;

  assign prod   = {{MASK_W{1'b0}}, pixel} * {{CH_W{1'b0}}, mask};
  assign rnd    = {1'b0, prod} + (P_W+1)'(64'h8000_0000);
  assign v      = rnd[P_W:32];
  assign shaded = (v > (P_W-31)'({CH_W{1'b1}})) ? {CH_W{1'b1}} : v[CH_W-1:0];

endmodule

[rtl/radial_vignette_shading_unit.sv]
// Top level: separable quadratic vignette over a raster BGR pixel stream.
//   channel  | direction | contents
//   pix_in   | sink      | frame_start, pixel_b, pixel_g, pixel_r
//   pix_out  | source    | shaded_b, shaded_g, shaded_r, frame_last
//   cfg_*    | write     | cfg_wen, cfg_index, cfg_data
// A pixel steps through read, column, column wait, mask wait, shade and write, with a row
// factor wait at a row end and a row 0 wait on a frame start; all share one factor unit.
// Synchronous reset restores the register defaults and position 0 with a unit row factor.
// Output register holds a result under stall; the next pixel is taken meanwhile.
`timescale 1ns / 1ps
module radial_vignette_shading_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wen,
  input  logic [rvs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rvs_pkg::CFG_W-1:0]     cfg_data,
  rvs_in_if.sink                        pix_in,
  rvs_out_if.source                     pix_out
);
  import rvs_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_READ, S_ROW0_WAIT, S_COL, S_COL_WAIT, S_MASK_WAIT, S_SHADE,
    S_ROWF_WAIT, S_WRITE
  } state_t;

  state_t           state;
  logic [DIM_W-1:0] image_width;
  logic [DIM_W-1:0] image_height;
  logic [STR_W-1:0] strength_q16;
  logic [RCP_W-1:0] norm_recip_q32;

  logic [DIM_W-1:0]  w;
  logic [DIM_W-1:0]  h;
  logic [POS_W-1:0]  col;
  logic [POS_W-1:0]  row;
  logic [FAC_W-1:0]  rf;
  logic [MASK_W-1:0] mask;
  logic              fs;
  logic              last;
  logic [CH_W-1:0]   pix_b, pix_g, pix_r;
  logic [CH_W-1:0]   sh_b, sh_g, sh_r;
  logic [POS_W-1:0]  col_c, row_c;
  logic [DIM_W-1:0]  col_inc, row_inc;

  axis_req_t         axis_req;
  logic              axis_done;
  logic [FAC_W-1:0]  axis_f;
  logic              accept;
  logic              mem_we;
  pos_state_t        mem_rdata;
  logic              out_load;
  logic              axis_go;

  assign pix_in.ready = (state == S_IDLE);
  assign accept       = pix_in.valid && pix_in.ready;
  assign mem_we       = (state == S_WRITE);
  assign w            = clamp_dim(image_width);
  assign h            = clamp_dim(image_height);
  assign col_c        = ({1'b0, col} >= w) ? POS_W'(w - DIM_W'(1)) : col;
  assign row_c        = ({1'b0, row} >= h) ? POS_W'(h - DIM_W'(1)) : row;
  assign col_inc      = {1'b0, col} + DIM_W'(1);
  assign row_inc      = {1'b0, row} + DIM_W'(1);
  assign out_load     = (state == S_SHADE) && (!pix_out.valid || pix_out.ready);
  assign axis_go      = ((state == S_READ) && fs) || (state == S_COL) ||
                        (out_load && (col_inc >= w));

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width    <= WIDTH_RST;
      image_height   <= HEIGHT_RST;
      strength_q16   <= STRENGTH_RST;
      norm_recip_q32 <= RECIP_RST;
    end else if (cfg_wen) begin
      case (cfg_idx_t'(cfg_index))
        CFG_WIDTH:    image_width    <= cfg_data[DIM_W-1:0];
        CFG_HEIGHT:   image_height   <= cfg_data[DIM_W-1:0];
        CFG_STRENGTH: strength_q16   <= cfg_data[STR_W-1:0];
        CFG_RECIP:    norm_recip_q32 <= cfg_data[RCP_W-1:0];
        default: ;
      endcase
    end
  end

  rvs_state_mem u_mem (
    .clk   (clk),
    .rst   (rst),
    .we    (mem_we),
    .wdata ('{col: col, row: row, row_factor: rf}),
    .re    (accept),
    .rdata (mem_rdata)
  );

  rvs_axis u_axis (
    .clk      (clk),
    .rst      (rst),
    .req      (axis_req),
    .strength (strength_q16),
    .recip    (norm_recip_q32),
    .done     (axis_done),
    .f        (axis_f)
  );

  rvs_shade u_sh_b (.mask(mask), .pixel(pix_b), .shaded(sh_b));
  rvs_shade u_sh_g (.mask(mask), .pixel(pix_g), .shaded(sh_g));
  rvs_shade u_sh_r (.mask(mask), .pixel(pix_r), .shaded(sh_r));

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      axis_req      <= '0;
      pix_out.valid <= 1'b0;
    end else begin
      axis_req.start <= axis_go;
      if (out_load) begin
        pix_out.valid <= 1'b1;
      end else if (pix_out.ready) begin
        pix_out.valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            fs    <= pix_in.frame_start;
            pix_b <= pix_in.pixel_b;
            pix_g <= pix_in.pixel_g;
            pix_r <= pix_in.pixel_r;
            state <= S_READ;
          end
        end
        S_READ: begin
          if (fs) begin
            col          <= '0;
            row          <= '0;
            axis_req.pos <= '0;
            axis_req.dim <= h;
            state        <= S_ROW0_WAIT;
          end else begin
            col   <= mem_rdata.col;
            row   <= mem_rdata.row;
            rf    <= mem_rdata.row_factor;
            state <= S_COL;
          end
        end
        S_ROW0_WAIT: begin
          if (axis_done) begin
            rf    <= axis_f;
            state <= S_COL;
          end
        end
        S_COL: begin
          col          <= col_c;
          row          <= row_c;
          last         <= ({1'b0, col_c} == w - DIM_W'(1)) && ({1'b0, row_c} == h - DIM_W'(1));
          axis_req.pos <= col_c;
          axis_req.dim <= w;
          state        <= S_COL_WAIT;
        end
        S_COL_WAIT: begin
          if (axis_done) begin
            mask  <= {{FAC_W{1'b0}}, axis_f} * {{FAC_W{1'b0}}, rf};
            state <= S_MASK_WAIT;
          end
        end
        S_MASK_WAIT: begin
          state <= S_SHADE;
        end
        S_SHADE: begin
          if (out_load) begin
            pix_out.shaded_b   <= sh_b;
            pix_out.shaded_g   <= sh_g;
            pix_out.shaded_r   <= sh_r;
            pix_out.frame_last <= last;
            if (col_inc >= w) begin
              col          <= '0;
              axis_req.dim <= h;
              if (row_inc >= h) begin
                row          <= '0;
                axis_req.pos <= '0;
              end else begin
                row          <= row_inc[POS_W-1:0];
                axis_req.pos <= row_inc[POS_W-1:0];
              end
              state <= S_ROWF_WAIT;
            end else begin
              col   <= col_inc[POS_W-1:0];
              state <= S_WRITE;
            end
          end
        end
        S_ROWF_WAIT: begin
          if (axis_done) begin
            rf    <= axis_f;
            state <= S_WRITE;
          end
        end
        S_WRITE: begin
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_done_waits: assert property (@(posedge clk) disable iff (rst)
    axis_done |-> (state == S_ROW0_WAIT || state == S_COL_WAIT || state == S_ROWF_WAIT))
    else $error("factor unit finished outside a wait state");

  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_WRITE) |-> ({1'b0, col} < w))
    else $error("column beyond width at write-back");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (state == S_SHADE && pix_out.valid && !pix_out.ready) |=> (state == S_SHADE))
    else $error("result advanced over a stalled output");

endmodule

[sim/tb_top.sv]
// Self-checking testbench for the radial vignette shading unit.
`timescale 1ns / 1ps
module tb_top;
  import rvs_pkg::*;

  typedef struct packed {
    logic       fs;
    logic [7:0] b;
    logic [7:0] g;
    logic [7:0] r;
  } pixel_t;

  typedef struct packed {
    logic [7:0] b;
    logic [7:0] g;
    logic [7:0] r;
    logic       last;
  } shaded_t;

  typedef struct {
    pixel_t  px;
    logic    known;
    shaded_t want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wen = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  rvs_in_if  pix_in();
  rvs_out_if pix_out();

  radial_vignette_shading_unit dut (
    .clk(clk), .rst(rst), .cfg_wen(cfg_wen), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .pix_in(pix_in), .pix_out(pix_out)
  );

  always #5 clk = ~clk;

  logic [12:0] m_width, m_height;
  logic [16:0] m_strength;
  logic [31:0] m_recip;
  logic [11:0] m_col, m_row;
  logic [16:0] m_row_fac;

  shaded_t shaded_q[$];
  int errors = 0;
  int idle_pct = 38;
  bit rx_busy = 1'b0;

  function automatic logic [16:0] factor_of(logic [11:0] pos, logic [12:0] dim);
    logic [63:0] twice, a, t, q, sq;
    twice = 64'(pos) * 2;
    a = (twice >= 64'(dim)) ? twice - 64'(dim) : 64'(dim) - twice;
    t = a * a * 64'(m_recip);
    q = (t + 64'd32768) >> 16;
    if (q > 64'd131072) q = 64'd131072;
    sq = (64'(m_strength) * q + 64'd32768) >> 16;
    if (sq >= 64'd65536) return 17'd0;
    return 17'(64'd65536 - sq);
  endfunction

  function automatic logic [7:0] scale_channel(logic [7:0] p, logic [63:0] mask);
    logic [63:0] v;
    v = (64'(p) * mask + (64'd1 << 31)) >> 32;
    return (v > 64'd255) ? 8'd255 : v[7:0];
  endfunction

  function automatic logic [12:0] fit_dim(logic [12:0] d);
    if (d == 0) return 13'd1;
    if (d > 13'd4096) return 13'd4096;
    return d;
  endfunction

  function automatic shaded_t shade_pixel(pixel_t px);
    logic [12:0] w, h;
    logic [16:0] fx;
    logic [63:0] mask;
    shaded_t o;
    w = fit_dim(m_width);
    h = fit_dim(m_height);
    if (px.fs) begin
      m_col = 0;
      m_row = 0;
      m_row_fac = factor_of(12'd0, h);
    end
    if (13'(m_col) >= w) m_col = 12'(w - 1);
    if (13'(m_row) >= h) m_row = 12'(h - 1);
    fx = factor_of(m_col, w);
    mask = 64'(fx) * 64'(m_row_fac);
    o.b = scale_channel(px.b, mask);
    o.g = scale_channel(px.g, mask);
    o.r = scale_channel(px.r, mask);
    o.last = (13'(m_col) == w - 1) && (13'(m_row) == h - 1);
    if (13'(m_col) + 1 >= w) begin
      m_col = 0;
      m_row = (13'(m_row) + 1 >= h) ? 12'd0 : m_row + 1;
      m_row_fac = factor_of(m_row, h);
    end else begin
      m_col = m_col + 1;
    end
    return o;
  endfunction

  task automatic write_reg(cfg_idx_t idx, logic [31:0] val);
    cfg_wen <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      CFG_WIDTH:    m_width = val[12:0];
      CFG_HEIGHT:   m_height = val[12:0];
      CFG_STRENGTH: m_strength = val[16:0];
      default:      m_recip = val;
    endcase
    @(negedge clk);
    cfg_wen <= 1'b0;
    @(negedge clk);
  endtask

  task automatic drain();
    pix_in.valid <= 1'b0;
    while (shaded_q.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic send_pixel(pixel_t px, logic known, shaded_t want);
    shaded_t pred;
    while ($urandom_range(99) < idle_pct) begin
      pix_in.valid <= 1'b0;
      @(negedge clk);
    end
    pix_in.valid <= 1'b1;
    pix_in.frame_start <= px.fs;
    pix_in.pixel_b <= px.b;
    pix_in.pixel_g <= px.g;
    pix_in.pixel_r <= px.r;
    do @(posedge clk); while (!pix_in.ready);
    pred = shade_pixel(px);
    if (known && pred != want)
      $display("%0t table row disagrees: expected %h predicted %h", $time, want, pred);
    shaded_q.push_back(known ? want : pred);
    @(negedge clk);
  endtask

  task automatic set_frame(logic [12:0] w, logic [12:0] h, logic [16:0] s);
    logic [31:0] n;
    n = (w == 0 || h == 0) ? 32'd1 : 32'(w) * w + 32'(h) * h;
    write_reg(CFG_WIDTH, 32'(w));
    write_reg(CFG_HEIGHT, 32'(h));
    write_reg(CFG_STRENGTH, 32'(s));
    write_reg(CFG_RECIP, 32'((64'd1 << 32) / n));
  endtask

  always @(posedge clk) begin
    shaded_t got, want;
    if (!rst && pix_out.valid && pix_out.ready) begin
      got = '{pix_out.shaded_b, pix_out.shaded_g, pix_out.shaded_r, pix_out.frame_last};
      if (shaded_q.size() == 0) begin
        $display("%0t unexpected transfer: actual %h", $time, got);
        errors++;
      end else begin
        want = shaded_q.pop_front();
        if (got != want) begin
          $display("%0t mismatch: expected %h actual %h", $time, want, got);
          errors++;
        end
      end
    end
  end

  always @(negedge clk)
    pix_out.ready <= rx_busy ? 1'b1 : ($urandom_range(99) >= idle_pct);

  stim_row_t rows[$];
  initial begin
    pixel_t px;
    int n;
    pix_in.valid = 1'b0;
    pix_in.frame_start = 1'b0;
    pix_in.pixel_b = '0;
    pix_in.pixel_g = '0;
    pix_in.pixel_r = '0;
    m_width = 640; m_height = 480; m_strength = 32768; m_recip = 7158;
    m_col = 0; m_row = 0; m_row_fac = 17'd65536;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // after reset row 0 keeps the unit row factor without a frame start
    rows.push_back('{'{1'b0, 8'hFF, 8'h00, 8'h80}, 1'b0, '0});
    rows.push_back('{'{1'b0, 8'h00, 8'hFF, 8'h01}, 1'b0, '0});
    foreach (rows[i]) send_pixel(rows[i].px, rows[i].known, rows[i].want);
    drain();
    rows.delete();

    // zero strength: unit mask, pixels pass, last flag on 1x1
    set_frame(13'd1, 13'd1, 17'd0);
    rows.push_back('{'{1'b1, 8'hFF, 8'hFF, 8'hFF}, 1'b1, '{8'hFF, 8'hFF, 8'hFF, 1'b1}});
    rows.push_back('{'{1'b0, 8'h00, 8'h00, 8'h00}, 1'b1, '{8'h00, 8'h00, 8'h00, 1'b1}});
    rows.push_back('{'{1'b0, 8'hAA, 8'h55, 8'h01}, 1'b1, '{8'hAA, 8'h55, 8'h01, 1'b1}});
    foreach (rows[i]) send_pixel(rows[i].px, rows[i].known, rows[i].want);
    drain();
    rows.delete();

    // full strength, huge reciprocal: factor floors at zero away from centre
    set_frame(13'd4, 13'd3, 17'd65536);
    write_reg(CFG_RECIP, 32'hFFFF_FFFF);
    for (int i = 0; i < 12; i++)
      rows.push_back('{'{i == 0, 8'hFF, 8'h80, 8'h7F}, 1'b0, '0});
    foreach (rows[i]) send_pixel(rows[i].px, rows[i].known, rows[i].want);
    drain();
    rows.delete();

    // zero and oversize dimensions
    write_reg(CFG_WIDTH, 32'h0000_0000);
    write_reg(CFG_HEIGHT, 32'h0000_1FFF);
    write_reg(CFG_STRENGTH, 32'h0001_FFFF);
    write_reg(CFG_RECIP, 32'd0);
    for (int i = 0; i < 4; i++)
      send_pixel('{i == 0, 8'($urandom), 8'($urandom), 8'($urandom)}, 1'b0, '0);
    drain();

    for (int phase = 0; phase < 6; phase++) begin
      logic [12:0] w, h;
      w = (phase == 5) ? 13'd4096 : 13'($urandom_range(1, 9));
      h = (phase == 5) ? 13'd2 : 13'($urandom_range(1, 7));
      set_frame(w, h, (phase == 1) ? 17'd65536 : 17'($urandom_range(0, 65536)));
      if (phase == 2) write_reg(CFG_RECIP, $urandom);
      rx_busy = (phase == 3);
      idle_pct = (phase == 3) ? 0 : 38;
      n = 0;
      while (n < 150) begin
        px.fs = (n == 0) || ($urandom_range(99) < 3);
        px.b = 8'($urandom);
        px.g = 8'($urandom);
        px.r = 8'($urandom);
        send_pixel(px, 1'b0, '0);
        n++;
        if (n == 75 && phase == 0) drain();
        if (phase == 4 && n == 60) begin
          drain();
          write_reg(CFG_STRENGTH, 32'($urandom_range(0, 65536)));
          write_reg(CFG_WIDTH, 32'($urandom_range(1, 5)));
        end
      end
      drain();
    end
    rx_busy = 1'b0;
    idle_pct = 38;
    drain();

    if (errors == 0 && shaded_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("TB_ERROR");
    $finish;
  end
endmodule

[radial_vignette_shading_unit.f]
rtl/rvs_pkg.sv
rtl/rvs_ifs.sv
rtl/rvs_state_mem.sv
rtl/rvs_axis.sv
rtl/rvs_shade.sv
rtl/radial_vignette_shading_unit.sv
sim/tb_top.sv
